// ===== rtl/core/scb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scb_pkg;

  // screen geometry
  localparam logic [4:0] SCREEN_ROWS = 5'd25;
  localparam logic [6:0] SCREEN_COLS = 7'd80;
  localparam logic [4:0] WIN_TOP     = 5'd3;
  localparam logic [4:0] WIN_BOTTOM  = 5'd21;
  localparam logic [6:0] WIN_LEFT    = 7'd4;
  localparam logic [6:0] WIN_RIGHT   = 7'd76;
  localparam logic [6:0] FRAME_LEFT  = 7'd2;
  localparam logic [6:0] FRAME_RIGHT = 7'd77;
  localparam logic [4:0] FRAME_ROW   = 5'd2;
  localparam logic [4:0] STATUS_TOP  = 5'd0;
  localparam logic [4:0] STATUS_SUB  = 5'd1;
  localparam logic [4:0] STATUS_LO0  = 5'd22;
  localparam logic [4:0] STATUS_LO1  = 5'd23;
  localparam logic [4:0] STATUS_BOT  = 5'd24;
  localparam logic [6:0] WIN_W       = 7'd73;
  localparam logic [4:0] WIN_H       = 5'd19;

  // attributes
  localparam logic [7:0] ATTR_CONTENT = 8'h1f;
  localparam logic [7:0] ATTR_FRAME   = 8'h70;
  localparam logic [7:0] ATTR_TOP     = 8'h30;
  localparam logic [7:0] ATTR_BAR     = 8'h17;
  localparam logic [7:0] ATTR_BOTTOM  = 8'h10;
  localparam logic [7:0] ATTR_PLAIN_RST = 8'h0f;
  localparam logic [7:0] ATTR_NONE    = 8'h00;

  // characters
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5c;

  // op codes
  localparam logic [2:0] OP_CHAR   = 3'd0;
  localparam logic [2:0] OP_SCROLL = 3'd1;
  localparam logic [2:0] OP_TOP    = 3'd2;
  localparam logic [2:0] OP_BOTTOM = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  // register indexes
  localparam logic CFG_FRAMED = 1'b0;
  localparam logic CFG_PLAIN  = 1'b1;

  typedef enum logic [3:0] {
    K_NOP, K_CHAR, K_NEWLINE, K_RETURN, K_BKSP,
    K_SCROLL, K_TOP, K_BOTTOM, K_CLEAR, K_READ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         ch;
    logic signed [10:0] delta;
    logic [4:0]         row;
    logic [6:0]         col;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [8:0] view_offset;
    logic [9:0] line_total;
  } res_t;

  typedef struct packed {
    logic       we;
    logic       index;
    logic [7:0] data;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/scb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/scb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [2:0]         in_op,
  input  wire logic [7:0]         in_char_code,
  input  wire logic signed [10:0] in_scroll_delta,
  input  wire logic [4:0]         in_cell_row,
  input  wire logic [6:0]         in_cell_col,
  output scb_pkg::cmd_t           cmd,
  output logic                    cmd_empty,
  input  wire logic               cmd_pop
);
  scb_pkg::cmd_t cls;

  // decode op and control characters into one command kind
  always_comb begin
    cls.ch    = in_char_code;
    cls.delta = in_scroll_delta;
    cls.row   = in_cell_row;
    cls.col   = in_cell_col;
    case (in_op)
      scb_pkg::OP_CHAR: begin
        if (in_char_code == scb_pkg::CH_NL) begin
          cls.kind = scb_pkg::K_NEWLINE;
        end else if (in_char_code == scb_pkg::CH_CR) begin
          cls.kind = scb_pkg::K_RETURN;
        end else if (in_char_code == scb_pkg::CH_BS) begin
          cls.kind = scb_pkg::K_BKSP;
        end else begin
          cls.kind = scb_pkg::K_CHAR;
        end
      end
      scb_pkg::OP_SCROLL: cls.kind = scb_pkg::K_SCROLL;
      scb_pkg::OP_TOP:    cls.kind = scb_pkg::K_TOP;
      scb_pkg::OP_BOTTOM: cls.kind = scb_pkg::K_BOTTOM;
      scb_pkg::OP_CLEAR:  cls.kind = scb_pkg::K_CLEAR;
      scb_pkg::OP_READ:   cls.kind = scb_pkg::K_READ;
      default:            cls.kind = scb_pkg::K_NOP;
    endcase
  end

  scb_fifo #(.W($bits(scb_pkg::cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cls),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (cmd_empty)
  );
endmodule
`default_nettype wire

// ===== rtl/core/scb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scb_back #(
  parameter int RING_LINES = 512,
  parameter int LINE_CHARS = 80
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  scb_pkg::cfg_t      cfg,
  input  scb_pkg::cmd_t      cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  output scb_pkg::res_t      res,
  output logic               res_push,
  input  wire logic          res_full
);
  localparam int IW = $clog2(RING_LINES);
  localparam int CW = $clog2(RING_LINES + 1);
  localparam int LW = $clog2(LINE_CHARS + 1);
  localparam int AW = $clog2(RING_LINES * LINE_CHARS);
  localparam int SW = ((CW > 11) ? CW : 11) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_CH_DEC, S_CH_BASE2, S_CH_PUT0,
    S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_RD_E, S_RESULT
  } state_t;

  state_t        state_r;
  scb_pkg::cmd_t cmd_r;
  logic          framed_r;
  logic [7:0]    plain_r;
  logic [IW-1:0] oldest_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] off_r;
  logic [LW-1:0] live_len_r;
  logic [AW-1:0] base_r;
  logic [CW-1:0] start_r;
  logic [IW-1:0] idx_r;
  logic          is_live_r;
  logic [7:0]    cell_char_r, cell_attr_r;

  // memories
  logic [7:0]    text_mem [RING_LINES * LINE_CHARS];
  logic [LW-1:0] len_mem  [RING_LINES];
  logic [7:0]    te_rdata_r;
  logic [LW-1:0] lm_rdata_r;
  logic          te_we, lm_we;
  logic [AW-1:0] te_waddr, te_raddr;
  logic [7:0]    te_wdata;

  // view geometry
  logic [6:0] vis_w, cbase;
  logic [4:0] vis_h, rbase;
  assign vis_w = framed_r ? scb_pkg::WIN_W : scb_pkg::SCREEN_COLS;
  assign vis_h = framed_r ? scb_pkg::WIN_H : scb_pkg::SCREEN_ROWS;
  assign rbase = framed_r ? scb_pkg::WIN_TOP : 5'd0;
  assign cbase = framed_r ? scb_pkg::WIN_LEFT : 7'd0;

  // live line index
  logic [IW:0]   live_sum;
  logic [IW-1:0] live_idx;
  assign live_sum = {1'b0, oldest_r} + (IW+1)'(count_r) - 1'b1;
  assign live_idx = (live_sum >= (IW+1)'(RING_LINES))
                  ? IW'(live_sum - (IW+1)'(RING_LINES)) : IW'(live_sum);

  // new line next values
  logic [IW-1:0] nl_oldest_nxt;
  logic [CW-1:0] nl_count_nxt;
  always_comb begin
    nl_oldest_nxt = oldest_r;
    nl_count_nxt  = count_r;
    if (count_r < CW'(RING_LINES)) begin
      nl_count_nxt = count_r + 1'b1;
    end else begin
      nl_oldest_nxt = (oldest_r == IW'(RING_LINES - 1)) ? '0 : oldest_r + 1'b1;
    end
  end

  // scroll limit and clamped offset
  logic [CW-1:0] max_off;
  logic [10:0]   mag;
  logic [SW-1:0] up_sum;
  logic [CW-1:0] scroll_nxt;
  assign max_off = (count_r > CW'(vis_h)) ? count_r - CW'(vis_h) : '0;
  assign mag     = cmd_r.delta[10] ? (~cmd_r.delta + 1'b1) : cmd_r.delta;
  assign up_sum  = SW'(off_r) + SW'(mag);
  always_comb begin
    if (cmd_r.delta[10]) begin
      scroll_nxt = (up_sum > SW'(max_off)) ? max_off : CW'(up_sum);
    end else if (mag != '0) begin
      scroll_nxt = (SW'(mag) > SW'(off_r)) ? '0 : off_r - CW'(mag);
    end else begin
      scroll_nxt = off_r;
    end
  end

  // char decision
  logic [7:0] len8, w8;
  logic       len_ge_w, len_wm1, bsl_fits, len_room;
  assign len8     = 8'(live_len_r);
  assign w8       = 8'(vis_w);
  assign len_ge_w = (len8 >= w8);
  assign len_wm1  = (len8 == w8 - 8'd1);
  assign bsl_fits = ((w8 - 8'd2) < 8'(LINE_CHARS));
  assign len_room = (len8 < 8'(LINE_CHARS));

  // cell classification
  logic [4:0] rr;
  logic [6:0] cc;
  logic       cl_content;
  logic [7:0] cl_attr;
  assign rr = cmd_r.row;
  assign cc = cmd_r.col;
  always_comb begin
    cl_content = 1'b0;
    cl_attr    = scb_pkg::ATTR_BAR;
    if (rr >= scb_pkg::SCREEN_ROWS || cc >= scb_pkg::SCREEN_COLS) begin
      cl_attr = scb_pkg::ATTR_NONE;
    end else if (!framed_r) begin
      cl_attr    = plain_r;
      cl_content = 1'b1;
    end else if (rr == scb_pkg::STATUS_TOP) begin
      cl_attr = scb_pkg::ATTR_TOP;
    end else if (rr == scb_pkg::STATUS_BOT) begin
      cl_attr = scb_pkg::ATTR_BOTTOM;
    end else if (rr == scb_pkg::STATUS_SUB || rr == scb_pkg::STATUS_LO0 ||
                 rr == scb_pkg::STATUS_LO1) begin
      cl_attr = scb_pkg::ATTR_BAR;
    end else if (rr == scb_pkg::FRAME_ROW) begin
      cl_attr = (cc >= scb_pkg::FRAME_LEFT && cc <= scb_pkg::FRAME_RIGHT)
              ? scb_pkg::ATTR_FRAME : scb_pkg::ATTR_BAR;
    end else if (cc == scb_pkg::FRAME_LEFT || cc == scb_pkg::FRAME_RIGHT) begin
      cl_attr = scb_pkg::ATTR_FRAME;
    end else if (cc < scb_pkg::WIN_LEFT || cc > scb_pkg::WIN_RIGHT) begin
      cl_attr = scb_pkg::ATTR_BAR;
    end else begin
      cl_attr    = scb_pkg::ATTR_CONTENT;
      cl_content = 1'b1;
    end
  end

  // first shown line
  logic [CW:0] h_off;
  logic [CW-1:0] start_nxt;
  assign h_off     = (CW+1)'(vis_h) + (CW+1)'(off_r);
  assign start_nxt = ((CW+1)'(count_r) > h_off) ? CW'((CW+1)'(count_r) - h_off) : '0;

  // logical line of the cell and its ring index
  logic [4:0]    view_row;
  logic [6:0]    xcol;
  logic [CW:0]   logical;
  logic          in_range;
  logic [IW+1:0] idx_sum;
  logic [IW-1:0] idx_nxt;
  assign view_row = rr - rbase;
  assign xcol     = cc - cbase;
  assign logical  = (CW+1)'(start_r) + (CW+1)'(view_row);
  assign in_range = (logical < (CW+1)'(count_r));
  assign idx_sum  = (IW+2)'(oldest_r) + (IW+2)'(logical);
  assign idx_nxt  = (idx_sum >= (IW+2)'(RING_LINES))
                  ? IW'(idx_sum - (IW+2)'(RING_LINES)) : IW'(idx_sum);

  // line length for the cell read
  logic [7:0] rd_len;
  logic       rd_hit;
  assign rd_len = is_live_r ? 8'(live_len_r) : 8'(lm_rdata_r);
  assign rd_hit = (8'(xcol) < rd_len) && (xcol < vis_w) && (8'(xcol) < 8'(LINE_CHARS));

  // memory ports
  always_comb begin
    te_we    = 1'b0;
    te_waddr = base_r;
    te_wdata = cmd_r.ch;
    lm_we    = 1'b0;
    case (state_r)
      S_CH_DEC: begin
        if (len_ge_w) begin
          lm_we = 1'b1;
        end else if (len_wm1) begin
          lm_we    = 1'b1;
          te_we    = bsl_fits;
          te_waddr = base_r + AW'(w8 - 8'd2);
          te_wdata = scb_pkg::CH_BSL;
        end else begin
          te_we    = len_room;
          te_waddr = base_r + AW'(live_len_r);
        end
      end
      S_CH_PUT0: te_we = 1'b1;
      S_EXEC:    lm_we = (cmd_r.kind == scb_pkg::K_NEWLINE);
      default: ;
    endcase
  end
  assign te_raddr = base_r + AW'(xcol);

  always_ff @(posedge clk) begin
    if (te_we) begin
      text_mem[te_waddr] <= te_wdata;
    end
    te_rdata_r <= text_mem[te_raddr];
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      len_mem[live_idx] <= live_len_r;
    end
    lm_rdata_r <= len_mem[idx_r];
  end

  // cursor
  logic [4:0] used, crow;
  logic [6:0] ccol;
  always_comb begin
    used = (count_r < CW'(vis_h)) ? 5'(count_r) : vis_h;
    if (off_r == '0) begin
      crow = rbase + used - 5'd1;
      ccol = cbase + ((len8 < w8) ? 7'(live_len_r) : vis_w - 7'd1);
    end else begin
      crow = rbase + vis_h - 5'd1;
      ccol = cbase;
    end
  end

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty && !res_full;
  assign res_push = (state_r == S_RESULT);
  assign res.cell_char   = cell_char_r;
  assign res.cell_attr   = cell_attr_r;
  assign res.cursor_row  = crow;
  assign res.cursor_col  = ccol;
  assign res.view_offset = 9'(off_r);
  assign res.line_total  = 10'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      framed_r   <= 1'b1;
      plain_r    <= scb_pkg::ATTR_PLAIN_RST;
      oldest_r   <= '0;
      count_r    <= CW'(1);
      off_r      <= '0;
      live_len_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            cmd_r       <= cmd;
            cell_char_r <= 8'd0;
            cell_attr_r <= 8'd0;
            state_r     <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_RESULT;
          case (cmd_r.kind)
            scb_pkg::K_CHAR: begin
              base_r  <= AW'(live_idx) * AW'(LINE_CHARS);
              state_r <= S_CH_DEC;
            end
            scb_pkg::K_NEWLINE: begin
              oldest_r   <= nl_oldest_nxt;
              count_r    <= nl_count_nxt;
              off_r      <= '0;
              live_len_r <= '0;
            end
            scb_pkg::K_RETURN: live_len_r <= '0;
            scb_pkg::K_BKSP: begin
              if (live_len_r != '0) begin
                live_len_r <= live_len_r - 1'b1;
              end
            end
            scb_pkg::K_SCROLL: off_r <= scroll_nxt;
            scb_pkg::K_TOP:    off_r <= max_off;
            scb_pkg::K_BOTTOM: off_r <= '0;
            scb_pkg::K_CLEAR: begin
              oldest_r   <= '0;
              count_r    <= CW'(1);
              off_r      <= '0;
              live_len_r <= '0;
            end
            scb_pkg::K_READ: state_r <= S_RD_A;
            default: ;
          endcase
        end
        S_CH_DEC: begin
          if (len_ge_w || len_wm1) begin
            // wrap: close the live line and open a fresh one
            oldest_r   <= nl_oldest_nxt;
            count_r    <= nl_count_nxt;
            off_r      <= '0;
            live_len_r <= '0;
            state_r    <= S_CH_BASE2;
          end else begin
            if (len_room) begin
              live_len_r <= live_len_r + 1'b1;
            end
            state_r <= S_RESULT;
          end
        end
        S_CH_BASE2: begin
          base_r  <= AW'(live_idx) * AW'(LINE_CHARS);
          state_r <= S_CH_PUT0;
        end
        S_CH_PUT0: begin
          live_len_r <= LW'(1);
          state_r    <= S_RESULT;
        end
        S_RD_A: begin
          cell_char_r <= scb_pkg::CH_SPACE;
          cell_attr_r <= cl_attr;
          start_r     <= start_nxt;
          state_r     <= cl_content ? S_RD_B : S_RESULT;
        end
        S_RD_B: begin
          idx_r     <= idx_nxt;
          is_live_r <= (logical == (CW+1)'(count_r) - 1'b1);
          state_r   <= in_range ? S_RD_C : S_RESULT;
        end
        S_RD_C: begin
          base_r  <= AW'(idx_r) * AW'(LINE_CHARS);
          state_r <= S_RD_D;
        end
        S_RD_D: state_r <= rd_hit ? S_RD_E : S_RESULT;
        S_RD_E: begin
          cell_char_r <= te_rdata_r;
          state_r     <= S_RESULT;
        end
        S_RESULT: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
      // configuration must arrive only while idle; the block itself does not enforce this
      if (cfg.we) begin
        if (cfg.index == scb_pkg::CFG_FRAMED) begin
          framed_r <= cfg.data[0];
          off_r    <= '0;
        end else begin
          plain_r <= cfg.data;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/text_console_scrollback.sv =====
// Text console with a ring of scrollback lines.
// Input channel (in_*): push an item while in_full is low; in_op selects
//   put char, scroll by delta, jump top, jump bottom, clear, read cell.
// Result channel (out_*): one result per item, in order; valid while
//   out_empty is low, taken with out_pop. Every result carries the cursor,
//   view offset and line count after the item; cell fields only for reads.
// Config port (cfg_*): cfg_we writes register cfg_index (0 framed mode,
//   1 plain attribute) with cfg_data; write only while the block is idle.
// Throughput: one item at a time; the back sequencer works each item through
//   the text and length memories and takes the next only after its result.
// Front and back are split by a two-entry command queue, results leave
//   through a two-entry result queue; a stalled receiver fills it and then
//   the back holds, and the front fills and raises in_full.
// Reset (rst_n low, synchronous): framed mode, attribute 0x0f, one empty
//   line, live view; queues empty. No memory clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module text_console_scrollback #(
  parameter int RING_LINES = 512,
  parameter int LINE_CHARS = 80
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [2:0]         in_op,
  input  wire logic [7:0]         in_char_code,
  input  wire logic signed [10:0] in_scroll_delta,
  input  wire logic [4:0]         in_cell_row,
  input  wire logic [6:0]         in_cell_col,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [7:0]              out_cell_char,
  output logic [7:0]              out_cell_attr,
  output logic [4:0]              out_cursor_row,
  output logic [6:0]              out_cursor_col,
  output logic [8:0]              out_view_offset,
  output logic [9:0]              out_line_total,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  scb_pkg::cmd_t cmd;
  scb_pkg::cfg_t cfg;
  scb_pkg::res_t res, res_q;
  logic          cmd_empty, cmd_pop, res_push, res_full;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: classify and queue commands
  scb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_char_code    (in_char_code),
    .in_scroll_delta (in_scroll_delta),
    .in_cell_row     (in_cell_row),
    .in_cell_col     (in_cell_col),
    .cmd             (cmd),
    .cmd_empty       (cmd_empty),
    .cmd_pop         (cmd_pop)
  );

  // back: ring state, memories, cell reads
  scb_back #(.RING_LINES(RING_LINES), .LINE_CHARS(LINE_CHARS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // result queue decouples the receiver
  scb_fifo #(.W($bits(scb_pkg::res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_q),
    .empty (out_empty)
  );

  assign out_cell_char   = res_q.cell_char;
  assign out_cell_attr   = res_q.cell_attr;
  assign out_cursor_row  = res_q.cursor_row;
  assign out_cursor_col  = res_q.cursor_col;
  assign out_view_offset = res_q.view_offset;
  assign out_line_total  = res_q.line_total;
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Testbench for the scrollback text console: drives items through the queue-style
// input, predicts every result with a behavioral model of the console, and
// compares each popped result as a whole against the oldest prediction.

class console_scoreboard;
  localparam int RING  = 512;
  localparam int LCH   = 80;

  // console state
  byte unsigned text_mem[RING*LCH];
  int           len_mem[RING];
  int           oldest;
  int           count;
  int           offset;
  bit           framed;
  logic [7:0]   plain_attr;

  scb_pkg::res_t pending[$];
  int            mismatches;

  function new();
    framed     = 1'b1;
    plain_attr = 8'h0f;
    mismatches = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (text_mem[i]) text_mem[i] = 8'h00;
    foreach (len_mem[i]) len_mem[i] = 0;
    oldest = 0;
    count  = 1;
    offset = 0;
  endfunction

  function int width();
    return framed ? 73 : 80;
  endfunction

  function int height();
    return framed ? 19 : 25;
  endfunction

  function int top_max();
    return (count > height()) ? count - height() : 0;
  endfunction

  function int live();
    return (oldest + count + RING - 1) % RING;
  endfunction

  function void open_line();
    int idx;
    offset = 0;
    if (count < RING) begin
      idx = (oldest + count) % RING;
      count++;
      len_mem[idx] = 0;
    end else begin
      oldest = (oldest + 1) % RING;
      len_mem[live()] = 0;
    end
  endfunction

  function void put_char(logic [7:0] ch);
    int idx;
    int w;
    idx = live();
    w = width();
    if (len_mem[idx] >= w) begin
      open_line();
      idx = live();
    end else if (len_mem[idx] == w - 1) begin
      // line about to overflow: mark it with a backslash and wrap
      text_mem[idx*LCH + w - 2] = scb_pkg::CH_BSL;
      open_line();
      idx = live();
    end
    if (len_mem[idx] < LCH) begin
      text_mem[idx*LCH + len_mem[idx]] = ch;
      len_mem[idx]++;
    end
  endfunction

  function void write_cfg(logic idx, logic [7:0] data);
    if (idx == scb_pkg::CFG_FRAMED) begin
      framed = data[0];
      offset = 0;
    end else begin
      plain_attr = data;
    end
  endfunction

  function void cell_lookup(int r, int c, output logic [7:0] ch, output logic [7:0] at);
    int start, logical, idx, view, x;
    ch = scb_pkg::CH_SPACE;
    if (r >= 25 || c >= 80) begin
      at = scb_pkg::ATTR_NONE;
      return;
    end
    if (framed) begin
      if (r == 0) begin at = scb_pkg::ATTR_TOP; return; end
      if (r == 24) begin at = scb_pkg::ATTR_BOTTOM; return; end
      if (r == 1 || r == 22 || r == 23) begin at = scb_pkg::ATTR_BAR; return; end
      if (r == 2) begin
        at = (c >= 2 && c <= 77) ? scb_pkg::ATTR_FRAME : scb_pkg::ATTR_BAR;
        return;
      end
      if (c == 2 || c == 77) begin at = scb_pkg::ATTR_FRAME; return; end
      if (c < 4 || c > 76) begin at = scb_pkg::ATTR_BAR; return; end
      at = scb_pkg::ATTR_CONTENT;
      view = r - 3;
      x = c - 4;
    end else begin
      at = plain_attr;
      view = r;
      x = c;
    end
    start = (count > height() + offset) ? count - height() - offset : 0;
    logical = start + view;
    if (logical < count) begin
      idx = (oldest + logical) % RING;
      if (x < len_mem[idx] && x < width() && x < LCH) ch = text_mem[idx*LCH + x];
    end
  endfunction

  // note an accepted item: update state and queue the expected result
  function void note_item(logic [2:0] op, logic [7:0] ch, logic signed [10:0] delta,
                          logic [4:0] row, logic [6:0] col);
    scb_pkg::res_t r;
    int mx, amt, used, len;
    r = '0;
    case (op)
      scb_pkg::OP_CHAR: begin
        if (ch == scb_pkg::CH_NL) open_line();
        else if (ch == scb_pkg::CH_CR) len_mem[live()] = 0;
        else if (ch == scb_pkg::CH_BS) begin
          if (len_mem[live()] > 0) len_mem[live()]--;
        end else put_char(ch);
      end
      scb_pkg::OP_SCROLL: begin
        mx = top_max();
        amt = (delta < 0) ? -int'(delta) : int'(delta);
        if (delta < 0) offset = (offset + amt > mx) ? mx : offset + amt;
        else if (delta > 0) offset = (amt > offset) ? 0 : offset - amt;
      end
      scb_pkg::OP_TOP:    offset = top_max();
      scb_pkg::OP_BOTTOM: offset = 0;
      scb_pkg::OP_CLEAR:  wipe();
      scb_pkg::OP_READ:   cell_lookup(int'(row), int'(col), r.cell_char, r.cell_attr);
      default: ;
    endcase
    if (offset == 0) begin
      len  = len_mem[live()];
      used = (count < height()) ? count : height();
      if (used == 0) used = 1;
      r.cursor_row = 5'((framed ? 3 : 0) + used - 1);
      r.cursor_col = 7'((framed ? 4 : 0) + ((len < width()) ? len : width() - 1));
    end else begin
      r.cursor_row = 5'((framed ? 3 : 0) + height() - 1);
      r.cursor_col = framed ? 7'd4 : 7'd0;
    end
    r.view_offset = offset[8:0];
    r.line_total  = count[9:0];
    pending.push_back(r);
  endfunction

  function void check_result(scb_pkg::res_t got);
    scb_pkg::res_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
    end
  endfunction
endclass

module testbench;

  // op codes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [2:0]         in_op;
  logic [7:0]         in_char_code;
  logic signed [10:0] in_scroll_delta;
  logic [4:0]         in_cell_row;
  logic [6:0]         in_cell_col;
  logic               out_empty;
  logic               out_pop;
  logic [7:0]         out_cell_char;
  logic [7:0]         out_cell_attr;
  logic [4:0]         out_cursor_row;
  logic [6:0]         out_cursor_col;
  logic [8:0]         out_view_offset;
  logic [9:0]         out_line_total;
  logic               cfg_we;
  logic               cfg_index;
  logic [7:0]         cfg_data;

  console_scoreboard board;
  bit  calm;      // no idling on either side in the closing phase
  bit  hold_rx;   // long receiver hold-off request
  int  cycles;

  text_console_scrollback dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_op(in_op),
    .in_char_code(in_char_code), .in_scroll_delta(in_scroll_delta),
    .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_cell_char(out_cell_char), .out_cell_attr(out_cell_attr),
    .out_cursor_row(out_cursor_row), .out_cursor_col(out_cursor_col),
    .out_view_offset(out_view_offset), .out_line_total(out_line_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** text_console_scrollback: FAILED **");
      $finish;
    end
  end

  // one item: present at the falling edge, hold until accepted
  task automatic send_item(logic [2:0] op, logic [7:0] ch, logic signed [10:0] delta,
                           logic [4:0] row, logic [6:0] col);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_op = op;
    in_char_code = ch;
    in_scroll_delta = delta;
    in_cell_row = row;
    in_cell_col = col;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    board.note_item(op, ch, delta, row, col);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  // wait until every expected result is back, then let in-flight work settle
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    board.write_cfg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // random item; nl_pct sets how often a newline is sent
  task automatic random_item(int nl_pct, bit allow_clear);
    int pick;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h21, 8'h7e));
    if (pick < nl_pct) begin
      send_item(scb_pkg::OP_CHAR, scb_pkg::CH_NL, 11'($urandom), 5'($urandom),
                7'($urandom));
    end else if (pick < nl_pct + (100 - nl_pct) / 2) begin
      // plain characters dominate so lines fill and wrap
      if ($urandom_range(0, 19) == 0)
        ch = ($urandom_range(0, 1) == 0) ? scb_pkg::CH_BS : scb_pkg::CH_CR;
      send_item(scb_pkg::OP_CHAR, ch, 11'($urandom), 5'($urandom), 7'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // reads mostly on screen, a few outside it
        if ($urandom_range(0, 9) == 0)
          send_item(scb_pkg::OP_READ, 8'($urandom), 11'($urandom), 5'($urandom),
                    7'($urandom));
        else
          send_item(scb_pkg::OP_READ, 8'($urandom), 11'($urandom),
                    5'($urandom_range(0, 24)), 7'($urandom_range(0, 79)));
      end else if (pick < 70) begin
        send_item(scb_pkg::OP_SCROLL, 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                              : 11'($signed($urandom_range(0, 40)) - 20),
                  5'($urandom), 7'($urandom));
      end else if (pick < 80) begin
        send_item(scb_pkg::OP_TOP, 8'($urandom), 11'($urandom), 5'($urandom), 7'($urandom));
      end else if (pick < 90) begin
        send_item(scb_pkg::OP_BOTTOM, 8'($urandom), 11'($urandom), 5'($urandom),
                  7'($urandom));
      end else if (pick < 95 && allow_clear && $urandom_range(0, 3) == 0) begin
        send_item(scb_pkg::OP_CLEAR, 8'($urandom), 11'($urandom), 5'($urandom),
                  7'($urandom));
      end else begin
        send_item(($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B, 8'($urandom),
                  11'($urandom), 5'($urandom), 7'($urandom));
      end
    end
  endtask

  // receiver: random pop bursts, one long hold-off on request
  initial begin
    int gap;
    int hold;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_pop = 1'b0;
        hold = $urandom_range(250, 350);
        repeat (hold) @(negedge clk);
        hold_rx = 1'b0;
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_pop = 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      board.check_result('{out_cell_char, out_cell_attr, out_cursor_row, out_cursor_col,
                           out_view_offset, out_line_total});
  end

  initial begin
    int n;
    board = new();
    calm = 1'b0;
    hold_rx = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = scb_pkg::OP_CHAR;
    in_char_code = 8'h00;
    in_scroll_delta = '0;
    in_cell_row = '0;
    in_cell_col = '0;
    cfg_we = 1'b0;
    cfg_index = scb_pkg::CFG_FRAMED;
    cfg_data = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, each op, special characters, frame cells
    send_item(scb_pkg::OP_CHAR, scb_pkg::CH_BS, 11'sd0, 5'd0, 7'd0); // backspace on empty line
    send_item(scb_pkg::OP_CHAR, 8'hff, 11'h400, 5'd31, 7'd127);
    send_item(scb_pkg::OP_CHAR, 8'h00, 11'sd1023, 5'd0, 7'd0);
    send_item(scb_pkg::OP_CHAR, 8'h41, 11'sd0, 5'd0, 7'd0);
    send_item(scb_pkg::OP_CHAR, scb_pkg::CH_BS, 11'sd0, 5'd0, 7'd0);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd3, 7'd4);          // first content cell
    send_item(scb_pkg::OP_CHAR, scb_pkg::CH_CR, 11'sd0, 5'd0, 7'd0);
    for (int i = 0; i < 3; i++) send_item(scb_pkg::OP_CHAR, scb_pkg::CH_NL, 11'sd0, 5'd0, 7'd0);
    send_item(scb_pkg::OP_SCROLL, 8'h00, -11'sd512, 5'd0, 7'd0);
    send_item(scb_pkg::OP_SCROLL, 8'h00, 11'sd512, 5'd0, 7'd0);
    send_item(scb_pkg::OP_TOP, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_item(scb_pkg::OP_BOTTOM, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd0, 7'd10);         // status rows
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd1, 7'd10);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd2, 7'd2);          // frame top
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd2, 7'd1);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd10, 7'd77);        // frame side
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd10, 7'd79);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd24, 7'd0);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd25, 7'd0);         // off screen
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd0, 7'd80);
    send_item(OP_SPARE_A, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_item(OP_SPARE_B, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_item(scb_pkg::OP_CLEAR, 8'h00, 11'sd0, 5'd0, 7'd0);

    // framed, random mix; long receiver hold-off fills the queues
    hold_rx = 1'b1;
    for (n = 0; n < 20; n++) random_item(10, 1'b1);
    drain();

    // full screen with a random attribute
    write_reg(scb_pkg::CFG_FRAMED, 8'h00);
    write_reg(scb_pkg::CFG_PLAIN, 8'($urandom));
    for (n = 0; n < 10; n++) random_item(12, 1'b1);
    drain();

    // full screen, extreme attribute, newline heavy until the ring wraps
    write_reg(scb_pkg::CFG_PLAIN, 8'hff);
    n = 0;
    while (board.count < 512 || n < 5) begin
      random_item(97, 1'b0);
      if (board.count >= 512) n++;
    end
    drain();

    // back to framed, zero attribute, no idling at the end
    write_reg(scb_pkg::CFG_FRAMED, 8'h01);
    write_reg(scb_pkg::CFG_PLAIN, 8'h00);
    calm = 1'b1;
    // one long line: backslash marker and wrap with the ring full
    send_item(scb_pkg::OP_CHAR, scb_pkg::CH_CR, 11'sd0, 5'd0, 7'd0);
    for (n = 0; n < 74; n++)
      send_item(scb_pkg::OP_CHAR, 8'(8'h61 + n % 26), 11'sd0, 5'd0, 7'd0);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd20, 7'd75);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd20, 7'd4);
    send_item(scb_pkg::OP_READ, 8'h00, 11'sd0, 5'd21, 7'd4);
    for (n = 0; n < 5; n++) random_item(10, 1'b0);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("** text_console_scrollback: PASSED **");
    end else begin
      $display("** text_console_scrollback: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/scb_pkg.sv
rtl/core/scb_fifo.sv
rtl/core/scb_front.sv
rtl/core/scb_back.sv
rtl/core/text_console_scrollback.sv
test/testbench.sv
